// ===== sv/coin_row_minimax_interval_dp_unit_assert.svh =====
// Assertion macros for the checker file of the coin-row minimax unit.
`ifndef COIN_ROW_MINIMAX_INTERVAL_DP_UNIT_ASSERT_SVH
`define COIN_ROW_MINIMAX_INTERVAL_DP_UNIT_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define CRMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CRMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/crmi_pkg.sv =====
// Shared constants for the coin-row minimax interval unit.
package crmi_pkg;

  localparam int unsigned MAX_COINS   = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_COINS);
  localparam int unsigned CNT_W       = $clog2(MAX_COINS + 1);
  localparam int unsigned TBL_DEPTH   = MAX_COINS * MAX_COINS;
  localparam int unsigned TBL_AW      = 2 * IDX_W;

  localparam int unsigned COIN_W      = 31;
  localparam int unsigned TBL_W       = 38;
  localparam int unsigned BEST_W      = 37;

  localparam int unsigned IN_TDATA_W  = ((COIN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((BEST_W + 7) / 8) * 8;

endpackage

// ===== sv/coin_row_minimax_interval_dp_unit.sv =====
// Coin-row minimax: loads a row of coins, fills the interval table, emits the row value.
//
//  channel  | dir | tdata                      | tuser     | tlast
//  s_axis   | in  | [30:0] coin_value          | -         | last_coin
//  m_axis   | out | [36:0] best_amount         | too_many  | -
//
// Loading accepts one coin per cycle while the input is ready. After the last coin of a
// row of n coins the table fill visits n*(n+1)/2 cells, then hands the result to the
// output register once it is free: for each cell the single read port of the table is
// walked through three reads, followed by two passes of the shared add/min unit
// and the write. Input is not ready during the fill. Reset clears the sequencer,
// the coin count and the overflow flag; the table and coin store are not cleared.
module coin_row_minimax_interval_dp_unit
  import crmi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [30:0] coin_value
  input  logic                   s_axis_tlast_i,   // last_coin
  // master side
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [36:0] best_amount
  output logic                   m_axis_tuser_o    // [0] too_many
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RD0  = 8'b0000_0010,
    ST_RD1  = 8'b0000_0100,
    ST_RD2  = 8'b0000_1000,
    ST_RD3  = 8'b0001_0000,
    ST_RDR  = 8'b0010_0000,
    ST_WR   = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  // Control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] nlast_q, nlast_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             row_ovf_q, row_ovf_d;
  logic             m_valid_q, m_valid_d;

  // Datapath registers
  logic [COIN_W-1:0] ci_q, cj_q;
  logic [TBL_W-1:0]  ta_q, tb_q, tc_q;
  logic [TBL_W-1:0]  left_q, right_q, cell_q;
  logic [BEST_W-1:0] best_q;
  logic              too_many_q;

  // Memories
  logic [COIN_W-1:0] coin_mem [MAX_COINS];
  logic [TBL_W-1:0]  tbl_mem  [TBL_DEPTH];
  logic [COIN_W-1:0] coin_rd_q;
  logic [TBL_W-1:0]  tbl_rd_q;

  logic              in_acc, out_free, full, small_k;
  logic [CNT_W-1:0]  count_new;
  logic [IDX_W-1:0]  j_idx, coin_rd_addr;
  logic [TBL_AW-1:0] tbl_rd_addr, tbl_wr_addr;
  logic [COIN_W-1:0] unit_coin;
  logic [TBL_W-1:0]  unit_x, unit_y, unit_min, unit_sum, cell_val;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign full            = (count_q == CNT_W'(MAX_COINS));
  assign count_new       = full ? count_q : count_q + CNT_W'(1);
  assign j_idx           = i_q + k_q;
  // single coins and pairs see no inner table values
  assign small_k         = (k_q < IDX_W'(2));

  // Read address sequence: (i+2,j), (i+1,j-1), (i,j-2)
  always_comb begin
    unique case (state_q)
      ST_RD0:  tbl_rd_addr = {i_q + IDX_W'(2), j_idx};
      ST_RD1:  tbl_rd_addr = {i_q + IDX_W'(1), j_idx - IDX_W'(1)};
      default: tbl_rd_addr = {i_q, j_idx - IDX_W'(2)};
    endcase
  end
  assign tbl_wr_addr  = {i_q, j_idx};
  assign coin_rd_addr = (state_q == ST_RD0) ? i_q : j_idx;

  // Shared unit: coin + min(x, y), wrapping at table width
  always_comb begin
    if (state_q == ST_RDR) begin
      unit_coin = cj_q;
      unit_x    = tb_q;
      unit_y    = tc_q;
    end else begin
      unit_coin = ci_q;
      unit_x    = ta_q;
      unit_y    = tb_q;
    end
    unit_min = (unit_x < unit_y) ? unit_x : unit_y;
    unit_sum = {{(TBL_W-COIN_W){1'b0}}, unit_coin} + unit_min;
  end

  assign cell_val = (left_q > right_q) ? left_q : right_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    k_d       = k_q;
    nlast_d   = nlast_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    row_ovf_d = row_ovf_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d = count_new;
          if (full) begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            nlast_d   = IDX_W'(count_new - CNT_W'(1));
            row_ovf_d = ovf_q | full;
            count_d   = '0;
            ovf_d     = 1'b0;
            i_d       = '0;
            k_d       = '0;
            state_d   = ST_RD0;
          end
        end
      end
      ST_RD0: state_d = ST_RD1;
      ST_RD1: state_d = ST_RD2;
      ST_RD2: state_d = ST_RD3;
      ST_RD3: state_d = ST_RDR;
      ST_RDR: state_d = ST_WR;
      ST_WR: begin
        if (j_idx == nlast_q) begin
          if (k_q == nlast_q) begin
            state_d = ST_FIN;
          end else begin
            k_d     = k_q + IDX_W'(1);
            i_d     = '0;
            state_d = ST_RD0;
          end
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_RD0;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      k_q       <= '0;
      nlast_q   <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      row_ovf_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      k_q       <= k_d;
      nlast_q   <= nlast_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      row_ovf_q <= row_ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Datapath captures
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_RD1: begin
        ci_q <= coin_rd_q;
        ta_q <= small_k ? '0 : tbl_rd_q;
      end
      ST_RD2: begin
        cj_q <= coin_rd_q;
        tb_q <= small_k ? '0 : tbl_rd_q;
      end
      ST_RD3: begin
        tc_q   <= small_k ? '0 : tbl_rd_q;
        left_q <= unit_sum;
      end
      ST_RDR: right_q <= unit_sum;
      ST_WR:  cell_q  <= cell_val;
      ST_FIN: begin
        if (out_free) begin
          best_q     <= cell_q[BEST_W-1:0];
          too_many_q <= row_ovf_q;
        end
      end
      default: ;
    endcase
  end

  // Coin store: written while loading, read one address a cycle
  always_ff @(posedge clk_i) begin
    if (in_acc && !full) begin
      coin_mem[count_q[IDX_W-1:0]] <= s_axis_tdata_i[COIN_W-1:0];
    end
    coin_rd_q <= coin_mem[coin_rd_addr];
  end

  // Interval table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WR) begin
      tbl_mem[tbl_wr_addr] <= cell_val;
    end
    tbl_rd_q <= tbl_mem[tbl_rd_addr];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-BEST_W){1'b0}}, best_q};
  assign m_axis_tuser_o  = too_many_q;

endmodule

// ===== sv/crmi_checker.sv =====
// Port-level checker for the coin-row minimax unit, bound to the top level.
`include "coin_row_minimax_interval_dp_unit_assert.svh"

module crmi_checker
  import crmi_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   s_axis_tlast_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tuser_o
);

  logic                      out_stall;
  logic                      last_acc;
  logic                      in_busy;
  logic [OUT_TDATA_W:0]      out_word;
  logic [OUT_TDATA_W-BEST_W-1:0] out_pad;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign last_acc  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign in_busy   = !s_axis_tready_o;
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};
  assign out_pad   = m_axis_tdata_o[OUT_TDATA_W-1:BEST_W];

  // a stalled result transaction holds its payload
  `CRMI_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_word), "result not held")

  // pad bits above best_amount stay zero
  `CRMI_ASSERT(a_out_pad, !m_axis_tvalid_o || (out_pad == '0), "nonzero pad bits in result")

  // the last coin of a row starts the fill, so input closes
  `CRMI_ASSERT_NEXT(a_busy_after_last, last_acc, !s_axis_tready_o, "input ready after last coin")

  // a new result only appears at the end of a fill
  `CRMI_ASSERT(a_result_after_fill, !$rose(m_axis_tvalid_o) || $past(in_busy), "early result")

endmodule

bind coin_row_minimax_interval_dp_unit crmi_checker u_crmi_checker (.*);

// ===== bench/coin_row_minimax_interval_dp_unit_checker.sv =====
`timescale 1ns / 1ps
// Stream checker for the coin-row minimax unit: predicts row values and compares results.
module coin_row_minimax_interval_dp_unit_checker
  import crmi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // coin stream seen at the block input
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,    // [30:0] coin_value
  input  logic                   s_tlast_i,    // last_coin
  // row results seen at the block output
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,    // [36:0] best_amount
  input  logic                   m_tuser_i,    // [0] too_many
  output int unsigned            fail_count_o,
  output int unsigned            rows_waiting_o,
  output int unsigned            rows_checked_o
);

  typedef struct packed {
    logic [BEST_W-1:0] best;
    logic              too_many;
  } row_result_t;

  // Predictor state: the stored row and the interval table built from it
  logic [COIN_W-1:0] row_coins [MAX_COINS];
  logic [TBL_W-1:0]  span_best [MAX_COINS][MAX_COINS];
  int unsigned       coins_held;
  logic              dropped_coin;

  row_result_t       expected_rows [$];
  row_result_t       want;
  logic [BEST_W-1:0] got_best;
  int unsigned       fail_count;
  int unsigned       rows_waiting;
  int unsigned       rows_checked;

  assign fail_count_o   = fail_count;
  assign rows_waiting_o = rows_waiting;
  assign rows_checked_o = rows_checked;

  function automatic logic [TBL_W-1:0] min_tbl(input logic [TBL_W-1:0] a,
                                               input logic [TBL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Best guaranteed total for the mover on coins 0..n-1, filled by span length
  function automatic logic [BEST_W-1:0] row_value(input int unsigned n);
    int unsigned      i;
    int unsigned      j;
    int unsigned      span;
    logic [TBL_W-1:0] mid;
    logic [TBL_W-1:0] take_left;
    logic [TBL_W-1:0] take_right;
    if (n == 0) return '0;
    for (i = 0; i < n; i++) span_best[i][i] = TBL_W'(row_coins[i]);
    for (i = 0; i + 1 < n; i++) begin
      span_best[i][i+1] = (row_coins[i] > row_coins[i+1]) ? TBL_W'(row_coins[i])
                                                          : TBL_W'(row_coins[i+1]);
    end
    for (span = 2; span < n; span++) begin
      for (i = 0; i + span < n; i++) begin
        j          = i + span;
        mid        = span_best[i+1][j-1];
        // sums wrap at the table width
        take_left  = TBL_W'(row_coins[i]) + min_tbl(span_best[i+2][j], mid);
        take_right = TBL_W'(row_coins[j]) + min_tbl(mid, span_best[i][j-2]);
        span_best[i][j] = (take_left > take_right) ? take_left : take_right;
      end
    end
    return span_best[0][n-1][BEST_W-1:0];
  endfunction

  // Result check first, then predict from the coin transaction of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coins_held   = 0;
      dropped_coin = 1'b0;
      fail_count   = 0;
      rows_waiting = 0;
      rows_checked = 0;
      expected_rows.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_best = m_tdata_i[BEST_W-1:0];
        if (rows_waiting == 0) begin
          if (fail_count < 10) begin
            $display("[%0t] unexpected result: best_amount=%0d too_many=%0b",
                     $realtime, got_best, m_tuser_i);
          end
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          rows_waiting--;
          rows_checked++;
          if (got_best !== want.best || m_tuser_i !== want.too_many) begin
            if (fail_count < 10) begin
              $display("[%0t] row %0d mismatch: best_amount exp=%0d act=%0d, too_many exp=%0b act=%0b",
                       $realtime, rows_checked, want.best, got_best, want.too_many,
                       m_tuser_i);
            end
            fail_count++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (coins_held < MAX_COINS) begin
          row_coins[coins_held] = s_tdata_i[COIN_W-1:0];
          coins_held++;
        end else begin
          // store full: coin is dropped
          dropped_coin = 1'b1;
        end
        if (s_tlast_i) begin
          want.best     = row_value(coins_held);
          want.too_many = dropped_coin;
          expected_rows.push_back(want);
          rows_waiting++;
          coins_held   = 0;
          dropped_coin = 1'b0;
        end
      end
    end
  end

endmodule

// ===== bench/coin_row_minimax_interval_dp_unit_tb.sv =====
`timescale 1ns / 1ps
// Top-level bench for the coin-row minimax unit: clock, reset, stimulus and verdict.
module coin_row_minimax_interval_dp_unit_tb
  import crmi_pkg::*;
();

  localparam int unsigned     ITEM_TARGET = 650;
  localparam int unsigned     CYCLE_LIMIT = 3000000;
  localparam int unsigned     HOLD_CYCLES = 600;
  localparam int unsigned     DRAIN_WAIT  = 100;
  localparam logic [COIN_W-1:0] COIN_MAX  = 31'h7FFFFFFF;
  localparam logic [COIN_W-1:0] COIN_P5   = 31'h55555555;
  localparam logic [COIN_W-1:0] COIN_PA   = 31'h2AAAAAAA;

  // Directed rows: bit 31 flags the last coin of a row
  localparam int unsigned DIR_COUNT = 24;
  localparam logic [31:0] DIRECTED [DIR_COUNT] = '{
    {1'b1, 31'd0},                                   // single zero coin
    {1'b1, COIN_MAX},                                // single top coin
    {1'b0, 31'd0}, {1'b1, COIN_MAX},                 // pairs, both orders
    {1'b0, COIN_MAX}, {1'b1, 31'd1},
    {1'b0, 31'd5}, {1'b0, 31'd3}, {1'b0, 31'd7}, {1'b1, 31'd10},
    {1'b0, COIN_MAX}, {1'b0, COIN_MAX}, {1'b1, COIN_MAX},
    {1'b0, COIN_P5}, {1'b0, COIN_PA}, {1'b0, COIN_P5}, {1'b0, COIN_PA}, {1'b1, 31'd1},
    {1'b0, 31'd8}, {1'b0, 31'd15}, {1'b0, 31'd3}, {1'b0, 31'd7}, {1'b0, 31'd1},
    {1'b1, 31'd20}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // [30:0] coin_value
  logic                   s_axis_tlast_i;   // last_coin
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [36:0] best_amount
  logic                   m_axis_tuser_o;   // [0] too_many

  int unsigned fail_count;
  int unsigned rows_waiting;
  int unsigned rows_checked;

  int unsigned phase;
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_request;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned coins_sent;
  int unsigned rows_sent;
  int unsigned full_rows;
  int unsigned over_rows;
  int unsigned total_fail;
  int unsigned row_len;
  int unsigned k;
  int unsigned pick;

  coin_row_minimax_interval_dp_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  coin_row_minimax_interval_dp_unit_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid_i),
    .s_tready_i     (s_axis_tready_o),
    .s_tdata_i      (s_axis_tdata_i),
    .s_tlast_i      (s_axis_tlast_i),
    .m_tvalid_i     (m_axis_tvalid_o),
    .m_tready_i     (m_axis_tready_i),
    .m_tdata_i      (m_axis_tdata_o),
    .m_tuser_i      (m_axis_tuser_o),
    .fail_count_o   (fail_count),
    .rows_waiting_o (rows_waiting),
    .rows_checked_o (rows_checked)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Coin value mix: zeros, top values, small values and full-width random
  function automatic logic [COIN_W-1:0] pick_coin();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return '0;
      1: return COIN_MAX;
      2: return COIN_W'($urandom_range(15));
      default: return COIN_W'($urandom);
    endcase
  endfunction

  // One coin transaction; returns at the falling edge after acceptance
  task automatic send_coin(input logic [COIN_W-1:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, value};
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    coins_sent++;
    if (last) rows_sent++;
    @(negedge clk_i);
  endtask

  // Random row of len coins, or all top values when all_max is set
  task automatic send_row(input int unsigned len, input logic all_max);
    int unsigned idx;
    if (len == MAX_COINS) full_rows++;
    if (len > MAX_COINS) over_rows++;
    for (idx = 0; idx < len; idx++) begin
      send_coin(all_max ? COIN_MAX : pick_coin(), idx == len - 1);
    end
  endtask

  // Idle rates per phase: sender-light, receiver-light, then none
  always_comb begin
    case (phase)
      0:       begin sender_idle_pct = 36; recv_idle_pct = 82; end
      1:       begin sender_idle_pct = 82; recv_idle_pct = 36; end
      default: begin sender_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  end

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    hold_left       = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    hold_request    = 1'b0;
    phase           = 0;
    coins_sent      = 0;
    rows_sent       = 0;
    full_rows       = 0;
    over_rows       = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows: extremes, pairs, bit patterns
    for (k = 0; k < DIR_COUNT; k++) begin
      send_coin(DIRECTED[k][COIN_W-1:0], DIRECTED[k][31]);
    end

    // full store at top values, then a row with dropped coins
    send_row(MAX_COINS, 1'b1);
    send_row(MAX_COINS + 2, 1'b0);

    // random rows, mostly short
    while (coins_sent < ITEM_TARGET) begin
      if (coins_sent >= 2 * ITEM_TARGET / 3) begin
        if (phase != 2) hold_request = 1'b1;
        phase = 2;
      end else if (coins_sent >= ITEM_TARGET / 3) begin
        phase = 1;
      end
      pick = $urandom_range(99);
      if (pick < 3)       row_len = MAX_COINS;
      else if (pick < 6)  row_len = $urandom_range(MAX_COINS + 6, MAX_COINS + 1);
      else if (pick < 15) row_len = $urandom_range(40, 13);
      else                row_len = $urandom_range(12, 1);
      send_row(row_len, 1'b0);
    end
    s_axis_tvalid_i <= 1'b0;

    // drain outstanding results
    while (rows_waiting > 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    total_fail = fail_count + rows_waiting;
    $display("Summary: %0d coins in %0d rows, %0d at full store and %0d with dropped coins",
             coins_sent, rows_sent, full_rows, over_rows);
    $display("Summary: %0d row values compared, %0d failures, %0d cycles",
             rows_checked, total_fail, cycle_count);
    if (total_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
